// ===== hdl/ascon_pkg.sv =====
`timescale 1ns / 1ps

package ascon_pkg;

	localparam int unsigned WordW     = 64;
	localparam int unsigned NumWords  = 5;
	localparam int unsigned NumRounds = 12;
	localparam int unsigned RcW       = 8;

	typedef logic [WordW-1:0] word_t;
	typedef word_t [NumWords-1:0] state_t;
	typedef logic [RcW-1:0] rc_t;

	localparam rc_t RoundConst [NumRounds] = '{
		8'hf0, 8'he1, 8'hd2, 8'hc3, 8'hb4, 8'ha5,
		8'h96, 8'h87, 8'h78, 8'h69, 8'h5a, 8'h4b
	};

	function automatic word_t rotr(word_t v, int unsigned amt);
		return (v >> amt) | (v << (WordW - amt));
	endfunction

	function automatic word_t diffuse(word_t v, int unsigned a, int unsigned b);
		return v ^ rotr(v, a) ^ rotr(v, b);
	endfunction

	// One full round: constant addition, substitution layer, linear diffusion.
	function automatic state_t round_fn(state_t s, rc_t rc);
		word_t a0, a1, a2, a3, a4;
		word_t b0, b1, b2, b3, b4;
		state_t r;
		a0 = s[0];
		a1 = s[1];
		a2 = s[2] ^ {{(WordW-RcW){1'b0}}, rc};
		a3 = s[3];
		a4 = s[4];
		a0 = a0 ^ a4;
		a4 = a4 ^ a3;
		a2 = a2 ^ a1;
		b0 = a0 ^ (~a1 & a2);
		b1 = a1 ^ (~a2 & a3);
		b2 = a2 ^ (~a3 & a4);
		b3 = a3 ^ (~a4 & a0);
		b4 = a4 ^ (~a0 & a1);
		b1 = b1 ^ b0;
		b0 = b0 ^ b4;
		b3 = b3 ^ b2;
		b2 = ~b2;
		r[0] = diffuse(b0, 19, 28);
		r[1] = diffuse(b1, 61, 39);
		r[2] = diffuse(b2, 1, 6);
		r[3] = diffuse(b3, 10, 17);
		r[4] = diffuse(b4, 7, 41);
		return r;
	endfunction

endpackage

// ===== hdl/ascon_in_if.sv =====
`timescale 1ns / 1ps

interface ascon_in_if import ascon_pkg::*; ();
	logic  valid;
	logic  ready;
	word_t word0;
	word_t word1;
	word_t word2;
	word_t word3;
	word_t word4;

	modport source (output valid, word0, word1, word2, word3, word4, input ready);
	modport sink (input valid, word0, word1, word2, word3, word4, output ready);
endinterface

// ===== hdl/ascon_out_if.sv =====
`timescale 1ns / 1ps

interface ascon_out_if import ascon_pkg::*; ();
	logic  valid;
	logic  ready;
	word_t out_word0;
	word_t out_word1;
	word_t out_word2;
	word_t out_word3;
	word_t out_word4;

	modport source (output valid, out_word0, out_word1, out_word2, out_word3, out_word4,
		input ready);
	modport sink (input valid, out_word0, out_word1, out_word2, out_word3, out_word4,
		output ready);
endinterface

// ===== hdl/ascon_permutation_12_rounds_top.sv =====
`timescale 1ns / 1ps

// Channel    Role    Handshake      Payload
// state_ch   sink    valid/ready    word0 .. word4, 64 bits each
// result_ch  source  valid/ready    out_word0 .. out_word4, 64 bits each
//
// Twelve register stages, one Ascon round each.
// A new transaction can be taken every cycle while results are drained.
// A stalled output holds its stage; earlier stages keep filling any empty slots.
// Reset clears only the stage valid bits; the state registers are not reset.

module ascon_permutation_12_rounds_top import ascon_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	ascon_in_if.sink   state_ch,
	ascon_out_if.source result_ch
);

	logic   valid_c [NumRounds+1];
	logic   ready_c [NumRounds+1];
	state_t state_c [NumRounds+1];

	assign valid_c[0]     = state_ch.valid;
	assign state_ch.ready = ready_c[0];
	assign state_c[0]     = {state_ch.word4, state_ch.word3, state_ch.word2,
		state_ch.word1, state_ch.word0};

	for (genvar i = 0; i < NumRounds; i++) begin : g_round
		ascon_round_stage u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.rc       (RoundConst[i]),
			.up_valid (valid_c[i]),
			.up_ready (ready_c[i]),
			.up_state (state_c[i]),
			.dn_valid (valid_c[i+1]),
			.dn_ready (ready_c[i+1]),
			.dn_state (state_c[i+1])
		);
	end

	assign result_ch.valid     = valid_c[NumRounds];
	assign ready_c[NumRounds]  = result_ch.ready;
	assign result_ch.out_word0 = state_c[NumRounds][0];
	assign result_ch.out_word1 = state_c[NumRounds][1];
	assign result_ch.out_word2 = state_c[NumRounds][2];
	assign result_ch.out_word3 = state_c[NumRounds][3];
	assign result_ch.out_word4 = state_c[NumRounds][4];

endmodule

// ===== hdl/ascon_round_stage.sv =====
`timescale 1ns / 1ps

module ascon_round_stage import ascon_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  rc_t    rc,
	input  logic   up_valid,
	output logic   up_ready,
	input  state_t up_state,
	output logic   dn_valid,
	input  logic   dn_ready,
	output state_t dn_state
);

	logic   valid_s1;
	state_t state_s1;

	// The stage takes a new transaction whenever it is empty or its contents move on.
	assign up_ready = !valid_s1 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			state_s1 <= round_fn(up_state, rc);
		end
	end

	assign dn_valid = valid_s1;
	assign dn_state = state_s1;

endmodule

// ===== hdl/ascon_chk.sv =====
`timescale 1ns / 1ps

module ascon_chk import ascon_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	input logic   in_ready,
	input logic   out_valid,
	input logic   out_ready,
	input state_t out_state
);

	// A stalled result stays offered.
	a_out_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn while stalled");

	// A stalled result keeps its value.
	a_out_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_state))
		else $error("result changed while stalled");

	// When the output stage is free, every stage is free to advance.
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || out_ready |-> in_ready)
		else $error("input stalled although the output is free");

	// A transaction needs twelve stages, so no result is offered when reset is released.
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result offered straight after reset");

endmodule

bind ascon_permutation_12_rounds_top ascon_chk u_ascon_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (state_ch.ready),
	.out_valid (result_ch.valid),
	.out_ready (result_ch.ready),
	.out_state ({result_ch.out_word4, result_ch.out_word3, result_ch.out_word2,
		result_ch.out_word1, result_ch.out_word0})
);
